// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/hdi_pkg.sv =====
// ----------------------------------------------------------------------------
// hdi_pkg
// Shared constants and types of the hot data identifier.
// ----------------------------------------------------------------------------
package hdi_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_RADIUS    = 64;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int TIME_BITS     = 32;
  // entry word: mark, time, count from the top down
  localparam int ENTRY_BITS    = 1 + TIME_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] REG_HOT_THR   = 2'd0;
  localparam logic [1:0] REG_LOCAL_THR = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;
  localparam logic [1:0] REG_HALF_LIFE = 2'd3;

  typedef struct packed {
    logic                  mark;
    logic [TIME_BITS-1:0]  stamp;
    logic [COUNT_BITS-1:0] count;
  } entry_t;
endpackage

// ===== design/hot_data_identifier.sv =====
// ----------------------------------------------------------------------------
// hot_data_identifier
// Page access classifier backed by a per-page table in one RAM.
// ----------------------------------------------------------------------------
// Input beats on s_axis (tdata: lpn, is_write, in_buffer; tuser: operation)
// produce one output beat on m_axis (tdata: hot, was_tracked, by_locality).
// Config writes on cfg_* set the four registers by index; write only while
// idle. After reset a clearing pass walks all TABLE_ENTRIES rows
// before the first beat is taken; cfg writes are taken throughout.
// One item at a time, all through the single RAM port: a hit, an evict or an
// unseen miss passes S_RD, S_EVAL, S_WR and S_OUT; a tracked miss adds S_MUL
// and S_CMP for the rate test, and a miss that falls through to the neighbour
// test adds 2*radius neighbour reads (S_NB_RD, S_NB_ACC) and S_NB_DEC. A
// buffered update at a half-life boundary adds a sweep that reads each table
// row and halves stale counts. The first item after a half_life write adds
// S_MOD to rebuild the decay phase bit by bit.
// A result stays in the output register until m_axis_tready; the next beat
// is taken once that register is free.
// The rate compare uses one 16x32 multiply registered before the compare.
// ----------------------------------------------------------------------------
module hot_data_identifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // lpn[31:0], is_write, in_buffer, pad
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // hot, was_tracked, by_locality, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hdi_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MOD, S_EVAL, S_MUL, S_CMP, S_NB_RD, S_NB_ACC, S_NB_DEC,
    S_WR, S_SW_RD, S_SW_WR, S_OUT
  } state_t;

  state_t state;
  logic [15:0] hot_thr, half_life;
  logic [8:0]  local_thr;
  logic [6:0]  radius;

  logic [31:0] lpn, time_cnt;
  logic op, wr, hit;
  logic [IDX_BITS-1:0] slot, sw_idx;
  logic [IDX_BITS:0] clr_idx;
  logic [7:0] nb_k;
  logic [6:0] r_sat;
  logic [7:0] present, bufd;
  logic tracked, hot, loc;
  entry_t cur;
  logic [47:0] prod;
  logic [15:0] phase;
  logic [31:0] age;
  logic decay;
  logic phase_stale;
  logic [4:0] mod_bit;
  logic [16:0] rem_shift;
  logic [15:0] rem_next;

  logic ram_we;
  logic [IDX_BITS-1:0] ram_addr;
  entry_t ram_wdata, ram_rdata;

  hdi_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready = 1'b1;

  logic [31:0] nb_page;
  assign nb_page = lpn - 32'(r_sat) + 32'(nb_k);
  assign age = time_cnt - cur.stamp;

  // one restoring step of time_cnt mod half_life, MSB first
  assign rem_shift = {phase, time_cnt[mod_bit]};
  assign rem_next = (rem_shift >= {1'b0, half_life}) ?
                    16'(rem_shift - {1'b0, half_life}) : rem_shift[15:0];

  entry_t upd;
  always_comb begin
    upd.count = (cur.count < COUNT_MAX) ? cur.count + 1'b1 : cur.count;
    upd.stamp = time_cnt;
    upd.mark  = hit | hot;
  end

  // RAM port mux
  always_comb begin
    ram_we = 1'b0;
    ram_addr = slot;
    ram_wdata = upd;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_idx[IDX_BITS-1:0];
        ram_wdata = '0;
      end
      S_IDLE: ram_addr = s_axis_tdata[IDX_BITS-1:0];
      S_NB_RD: ram_addr = nb_page[IDX_BITS-1:0];
      S_WR: begin
        ram_we = 1'b1;
        ram_wdata = op ? entry_t'('0) : upd;
      end
      S_SW_RD: ram_addr = sw_idx;
      S_SW_WR: begin
        ram_addr = sw_idx;
        ram_we = (time_cnt - ram_rdata.stamp) >= 32'(half_life);
        ram_wdata = ram_rdata;
        ram_wdata.count = ram_rdata.count >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      hot_thr <= 16'd256;
      local_thr <= 9'd128;
      radius <= 7'd4;
      half_life <= 16'd1000;
      time_cnt <= '0;
      phase <= '0;
      phase_stale <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HOT_THR:   hot_thr <= cfg_data;
          REG_LOCAL_THR: local_thr <= cfg_data[8:0];
          REG_RADIUS:    radius <= cfg_data[6:0];
          REG_HALF_LIFE: begin
            half_life <= cfg_data;
            phase_stale <= 1'b1;
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (IDX_BITS+1)'(TABLE_ENTRIES-1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          lpn <= s_axis_tdata[31:0];
          wr <= s_axis_tdata[32];
          hit <= s_axis_tdata[33];
          op <= s_axis_tuser;
          slot <= s_axis_tdata[IDX_BITS-1:0];
          hot <= 1'b0;
          loc <= 1'b0;
          if (!s_axis_tuser && s_axis_tdata[32]) time_cnt <= time_cnt + 1'b1;
          r_sat <= (radius > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : radius;
          state <= S_RD;
        end
        S_RD: begin
          // track the phase of the updated time incrementally; rebuild it
          // from scratch after a half_life write
          if (half_life == 16'd0) begin
            phase <= '0;
            phase_stale <= 1'b0;
            state <= S_EVAL;
          end else if (phase_stale) begin
            phase <= '0;
            mod_bit <= 5'd31;
            state <= S_MOD;
          end else begin
            if (!op && wr) phase <= (phase + 1'b1 >= half_life) ? '0 : phase + 1'b1;
            state <= S_EVAL;
          end
        end
        S_MOD: begin
          phase <= rem_next;
          mod_bit <= mod_bit - 1'b1;
          if (mod_bit == 5'd0) begin
            phase_stale <= 1'b0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cur <= ram_rdata;
          tracked <= ram_rdata.count != '0;
          nb_k <= '0;
          present <= '0;
          bufd <= '0;
          if (op) state <= S_WR;
          else if (hit) begin
            hot <= 1'b1;
            state <= S_WR;
          end else if (ram_rdata.count == '0) begin
            hot <= wr;
            state <= S_WR;
          end else state <= S_MUL;
        end
        S_MUL: begin
          prod <= hot_thr * age;
          state <= S_CMP;
        end
        S_CMP: begin
          if ({24'd0, cur.count, 8'd0} > prod) begin
            hot <= 1'b1;
            state <= S_WR;
          end else if (r_sat == '0) state <= S_WR;
          else state <= S_NB_RD;
        end
        S_NB_RD: state <= S_NB_ACC;
        S_NB_ACC: begin
          if (ram_rdata.count != '0) begin
            present <= present + 1'b1;
            if (ram_rdata.mark) bufd <= bufd + 1'b1;
          end
          nb_k <= nb_k + 1'b1;
          state <= (nb_k + 1'b1 == {r_sat, 1'b0}) ? S_NB_DEC : S_NB_RD;
        end
        S_NB_DEC: begin
          if (present != '0 && {bufd, 8'd0} > 16'(local_thr) * 16'(present)) begin
            hot <= 1'b1;
            loc <= 1'b1;
          end
          state <= S_WR;
        end
        S_WR: begin
          decay <= !op && (hit || hot) && half_life != '0 && phase == '0;
          sw_idx <= '0;
          if (!op && (hit || hot) && half_life != '0 && phase == '0) state <= S_SW_RD;
          else state <= S_OUT;
        end
        S_SW_RD: state <= S_SW_WR;
        S_SW_WR: begin
          sw_idx <= sw_idx + 1'b1;
          state <= (sw_idx == IDX_BITS'(TABLE_ENTRIES-1)) ? S_OUT : S_SW_RD;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {5'd0, loc, tracked, hot & !op};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_loc_hot, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[0], "locality without hot")
  `ASSERT_IMP(a_no_take_busy, state != S_IDLE, !s_axis_tready, "input taken while busy")
  `ASSERT_NXT(a_sweep_decay, state == S_SW_RD, decay, "sweep without decay")
endmodule

// ===== design/hdi_ram.sv =====
// ----------------------------------------------------------------------------
// hdi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module hdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== tb/hot_data_identifier_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hot_data_identifier_tb
// Self-checking bench: directed access/evict beats, then random page traffic
// clustered around moving table windows, under several register settings.
// Each accepted beat runs through a local model of the page table, and every
// output beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module hot_data_identifier_tb;
  import hdi_pkg::*;

  typedef struct packed {
    logic hot;
    logic tracked;
    logic locality;
  } verdict_t;

  typedef struct {
    logic        evict;
    logic [31:0] lpn;
    logic        wr;
    logic        hit;
    logic        typed;
    verdict_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  hot_data_identifier i_dut (.*);

  always #5 clk = ~clk;

  // shadow of the page table and registers
  logic [COUNT_BITS-1:0] shadow_count [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]  shadow_stamp [TABLE_ENTRIES];
  logic                  shadow_mark  [TABLE_ENTRIES];
  logic [31:0] tick;
  logic [15:0] phase;
  logic [15:0] thr_rate;
  logic [8:0]  thr_local;
  logic [6:0]  radius;
  logic [15:0] half_life;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int hot_seen = 0;
  int locality_seen = 0;
  bit quiet = 1'b0;

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void note_visit(int slot, logic buffered);
    if (shadow_count[slot] != COUNT_MAX) shadow_count[slot]++;
    shadow_stamp[slot] = tick;
    shadow_mark[slot] = buffered;
    // halve stale entries at a half-life boundary
    if (buffered && half_life != 0 && phase == 0) begin
      for (int k = 0; k < TABLE_ENTRIES; k++)
        if (32'(tick - shadow_stamp[k]) >= {16'd0, half_life})
          shadow_count[k] = shadow_count[k] >> 1;
    end
  endfunction

  function automatic logic neighbors_buffered(logic [31:0] lpn);
    int r;
    int present;
    int marked;
    int s;
    r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
    present = 0;
    marked = 0;
    for (int k = 0; k < 2 * r; k++) begin
      s = int'(32'(lpn - r + k) % TABLE_ENTRIES);
      if (shadow_count[s] != 0) begin
        present++;
        if (shadow_mark[s]) marked++;
      end
    end
    return present != 0 && (longint'(marked) * 256 > longint'(thr_local) * present);
  endfunction

  function automatic verdict_t classify_page(logic evict, logic [31:0] lpn, logic wr,
                                             logic hit);
    verdict_t v;
    int slot;
    logic [31:0] age;
    slot = int'(lpn % TABLE_ENTRIES);
    v = '0;
    v.tracked = shadow_count[slot] != 0;
    if (evict) begin
      shadow_count[slot] = '0;
      shadow_stamp[slot] = '0;
      shadow_mark[slot] = 1'b0;
      phase = (half_life != 0) ? 16'(tick % half_life) : 16'd0;
    end else begin
      if (wr) tick++;
      phase = (half_life != 0) ? 16'(tick % half_life) : 16'd0;
      if (hit) begin
        v.hot = 1'b1;
        note_visit(slot, 1'b1);
      end else begin
        if (v.tracked) begin
          age = tick - shadow_stamp[slot];
          if ({48'd0, shadow_count[slot]} * 64'd256 > {48'd0, thr_rate} * {32'd0, age})
            v.hot = 1'b1;
          else if (neighbors_buffered(lpn)) begin
            v.hot = 1'b1;
            v.locality = 1'b1;
          end
        end else begin
          v.hot = wr;
        end
        note_visit(slot, v.hot);
      end
    end
    return v;
  endfunction

  task automatic send_page(stim_row_t row);
    verdict_t v;
    if (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, row.hit, row.wr, row.lpn};
    s_axis_tuser <= row.evict;
    do @(posedge clk); while (!s_axis_tready);
    v = classify_page(row.evict, row.lpn, row.wr, row.hit);
    pending_verdicts.push_back(row.typed ? row.want : v);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HOT_THR:   thr_rate = value;
      REG_LOCAL_THR: thr_local = value[8:0];
      REG_RADIUS:    radius = value[6:0];
      REG_HALF_LIFE: half_life = value;
    endcase
  endtask

  task automatic set_regs(logic [15:0] rate, logic [8:0] loc, logic [6:0] rad,
                          logic [15:0] hl);
    write_reg(REG_HOT_THR, rate);
    write_reg(REG_LOCAL_THR, {7'd0, loc});
    write_reg(REG_RADIUS, {9'd0, rad});
    write_reg(REG_HALF_LIFE, hl);
  endtask

  task automatic random_pages(int count);
    stim_row_t row;
    logic [9:0] window;
    window = 10'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) window = 10'($urandom);
      row.evict = $urandom_range(99) < 8;
      row.wr = 1'($urandom_range(1));
      row.hit = $urandom_range(99) < 30;
      row.lpn = $urandom;
      // mostly pages near the current window so neighbors are populated
      if ($urandom_range(99) < 85)
        row.lpn[9:0] = window + 10'($urandom_range(0, 40));
      row.typed = 1'b0;
      row.want = '0;
      send_page(row);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && beats_seen == 400) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen <= beats_seen + 1;
      if (pending_verdicts.size() == 0) begin
        report("unexpected beat", m_axis_tdata, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] != want.hot) report("hot", m_axis_tdata[0], want.hot);
        if (m_axis_tdata[1] != want.tracked)
          report("was_tracked", m_axis_tdata[1], want.tracked);
        if (m_axis_tdata[2] != want.locality)
          report("by_locality", m_axis_tdata[2], want.locality);
        if (m_axis_tdata[0]) hot_seen++;
        if (m_axis_tdata[2]) locality_seen++;
      end
    end
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d beats outstanding", pending_verdicts.size());
    $display("hot_data_identifier test failed");
    $finish;
  end

  stim_row_t directed[] = '{
    // after reset: read of an unseen page is cold, write is hot
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 3'b000},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 3'b100},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 3'b000},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 3'b010},
    '{1'b0, 32'h8000_0005, 1'b0, 1'b1, 1'b1, 3'b100},
    '{1'b0, 32'h8000_0005, 1'b1, 1'b1, 1'b1, 3'b110},
    '{1'b0, 32'h0000_0005, 1'b0, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0004, 1'b1, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0006, 1'b1, 1'b1, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0003, 1'b1, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0007, 1'b1, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0007, 1'b1, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 3'b000},
    '{1'b0, 32'h5555_5555, 1'b0, 1'b1, 1'b0, 3'b000},
    '{1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 3'b000},
    '{1'b1, 32'h0000_0006, 1'b0, 1'b0, 1'b0, 3'b000},
    '{1'b0, 32'h0000_0006, 1'b0, 1'b0, 1'b0, 3'b000},
    '{1'b1, 32'h1234_5678, 1'b1, 1'b1, 1'b1, 3'b000}
  };

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      shadow_count[k] = '0;
      shadow_stamp[k] = '0;
      shadow_mark[k] = 1'b0;
    end
    tick = '0;
    phase = '0;
    thr_rate = 16'd256;
    thr_local = 9'd128;
    radius = 7'd4;
    half_life = 16'd1000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_page(directed[i]);
    s_axis_tvalid <= 1'b0;

    set_regs(16'd0, 9'd0, 7'd0, 16'd1);
    random_pages(200);
    set_regs(16'hFFFF, 9'd256, 7'd64, 16'hFFFF);
    random_pages(200);
    set_regs(16'd300, 9'd64, 7'd8, 16'd7);
    quiet <= 1'b1;
    random_pages(300);
    quiet <= 1'b0;
    for (int p = 0; p < 5; p++) begin
      set_regs(16'($urandom), 9'($urandom_range(0, 256)), 7'($urandom_range(0, 64)),
               16'($urandom_range(1, 60)));
      random_pages(100);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d page beats sent over 9 register settings; %0d results came back",
             items_sent, beats_seen);
    $display("%0d were hot, %0d of them hot through buffered neighbors",
             hot_seen, locality_seen);
    if (errors == 0) begin
      $display("hot_data_identifier test passed");
    end else begin
      $display("hot_data_identifier test failed");
    end
    $finish;
  end
endmodule
